[rtl/pwe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwe_pkg
// Shared types and constants of the periodic waveform evaluator.
// ----------------------------------------------------------------------------
package pwe_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_TIME   = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_FREQUENCY    = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_BASE_LEVEL   = 3'd4,
    REG_WAVEFORM     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_INV_SAW  = 2'd3
  } waveform_e;

  localparam logic [31:0] StartTimeRst   = 32'd0;
  localparam logic [31:0] PhaseOffsetRst = 32'd0;
  localparam logic [31:0] FrequencyRst   = 32'd65536;
  localparam logic [15:0] AmplitudeRst   = 16'd256;
  localparam logic [15:0] BaseLevelRst   = 16'd0;

  // pi/2 and 1.0 in Q2.30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  localparam logic [14:0] UnitMax = 15'd32767;

endpackage

`default_nettype wire

[rtl/pwe_sine_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwe_sine_rom
// Quarter-wave sine table, built at elaboration, with registered read.
// ----------------------------------------------------------------------------
module pwe_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AddrW-1:0] addr_i,
  output      logic [14:0]      data_o
);

  localparam int unsigned Entries = SINE_TABLE_DEPTH + 1;

  // q2.30 taylor series up to the 13th power, truncating steps
  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    t    = (64'(k) * pwe_pkg::HalfPiQ30 + 64'(SINE_TABLE_DEPTH / 2))
         / 64'(SINE_TABLE_DEPTH);
    sum  = t;
    term = t;
    for (int n = 1; n <= 6; n++) begin
      term = (term * t) >> 30;
      term = (term * t) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    e = (sum * 64'd32767 + (pwe_pkg::OneQ30 >> 1)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[14:0];
  endfunction

  logic [14:0] rom_w [Entries];

  for (genvar k = 0; k < Entries; k++) begin : g_rom
    localparam logic [14:0] Entry = sine_entry(k);
    assign rom_w[k] = Entry;
  end

  logic [14:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/periodic_waveform_evaluator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_waveform_evaluator
// Evaluates a configured sine, square, sawtooth or inverse sawtooth wave at each sample time.
// ----------------------------------------------------------------------------
// Takes one sample time per clock while s_axis_tready is high and returns one
// word per sample, in order. The six stages are: time difference, the 32x32 phase
// multiply, the table index multiply, the quadrant split with the sine table
// read, the 16x16 gain multiply, and rounding with saturation into the output
// register. A stalled output holds its word while the stages behind it keep
// filling bubbles. Configuration is written through the cfg channel, which is
// always ready; writes are meant for times when no sample is in flight.
module periodic_waveform_evaluator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [pwe_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [pwe_pkg::CfgDataW-1:0]   cfg_data_i,

  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [31:0]                    s_axis_tdata,   // [31:0] sample_time

  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [15:0]                    m_axis_tdata,   // [15:0] wave_value
  output      logic [0:0]                     m_axis_tuser    // [0] saturated
);

  localparam int unsigned FourD = 4 * SINE_TABLE_DEPTH;
  localparam int unsigned NW    = $clog2(FourD);
  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH + 1);

  // configuration registers
  logic [31:0]        start_time_q;
  logic [31:0]        phase_offset_q;
  logic [31:0]        frequency_q;
  logic signed [15:0] amplitude_q;
  logic signed [15:0] base_level_q;
  pwe_pkg::waveform_e waveform_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q   <= pwe_pkg::StartTimeRst;
      phase_offset_q <= pwe_pkg::PhaseOffsetRst;
      frequency_q    <= pwe_pkg::FrequencyRst;
      amplitude_q    <= pwe_pkg::AmplitudeRst;
      base_level_q   <= pwe_pkg::BaseLevelRst;
      waveform_q     <= pwe_pkg::WAVE_SINE;
    end else if (cfg_valid_i) begin
      unique case (pwe_pkg::cfg_reg_e'(cfg_index_i))
        pwe_pkg::REG_START_TIME:   start_time_q   <= cfg_data_i;
        pwe_pkg::REG_PHASE_OFFSET: phase_offset_q <= cfg_data_i;
        pwe_pkg::REG_FREQUENCY:    frequency_q    <= cfg_data_i;
        pwe_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data_i[15:0];
        pwe_pkg::REG_BASE_LEVEL:   base_level_q   <= cfg_data_i[15:0];
        pwe_pkg::REG_WAVEFORM:     waveform_q     <= pwe_pkg::waveform_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 1: time difference, wraps modulo 2^32
  logic [31:0] d1_d, d1_q;
  assign d1_d = s_axis_tdata - start_time_q - phase_offset_q;

  // stage 2: cycle position, low half of the product
  logic [63:0] phase_prod;
  logic [31:0] x2_d, x2_q;
  assign phase_prod = {32'd0, d1_q} * {32'd0, frequency_q};
  assign x2_d       = phase_prod[31:0];

  // stage 3: table index n = floor(x * 4D / 2^32)
  logic [63:0]   idx_prod;
  logic [NW-1:0] n3_d, n3_q;
  logic [31:0]   x3_q;
  assign idx_prod = {32'd0, x2_q} * 64'(FourD);
  assign n3_d     = idx_prod[32 +: NW];

  // stage 4: quadrant split, rom read, non-sine values
  logic [1:0]         quad4;
  logic [NW-1:0]      off4;
  logic [AddrW-1:0]   addr4;
  logic [32:0]        inv4;
  logic signed [15:0] alt4_d, alt4_q;
  logic               neg4_q;

  always_comb begin
    priority if (n3_q >= NW'(3 * SINE_TABLE_DEPTH)) begin
      quad4 = 2'd3;
      off4  = n3_q - NW'(3 * SINE_TABLE_DEPTH);
    end else if (n3_q >= NW'(2 * SINE_TABLE_DEPTH)) begin
      quad4 = 2'd2;
      off4  = n3_q - NW'(2 * SINE_TABLE_DEPTH);
    end else if (n3_q >= NW'(SINE_TABLE_DEPTH)) begin
      quad4 = 2'd1;
      off4  = n3_q - NW'(SINE_TABLE_DEPTH);
    end else begin
      quad4 = 2'd0;
      off4  = n3_q;
    end
  end

  // odd quadrants run the table backward
  assign addr4 = quad4[0] ? AddrW'(SINE_TABLE_DEPTH) - AddrW'(off4) : AddrW'(off4);
  assign inv4  = 33'h1_0000_0000 - {1'b0, x3_q};

  always_comb begin
    unique case (waveform_q)
      pwe_pkg::WAVE_SQUARE:  alt4_d = x3_q[31] ? 16'sh8000 : 16'sh7fff;
      pwe_pkg::WAVE_SAW:     alt4_d = {1'b0, x3_q[31:17]};
      pwe_pkg::WAVE_INV_SAW: alt4_d = inv4[32] ? 16'sh7fff : {1'b0, inv4[31:17]};
      default:               alt4_d = 16'sh0000;
    endcase
  end

  logic [14:0] rom_data;

  pwe_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (en4),
    .addr_i (addr4),
    .data_o (rom_data)
  );

  // stage 5: gain multiply with rounding bias
  logic signed [15:0] y5;
  logic signed [31:0] p5_d, p5_q;
  assign y5   = (waveform_q == pwe_pkg::WAVE_SINE)
              ? (neg4_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data}))
              : alt4_q;
  assign p5_d = 32'(y5) * 32'(amplitude_q) + 32'sd16384;

  // stage 6: floor shift, offset, saturate
  logic signed [16:0] scaled6;
  logic signed [17:0] r6;
  logic [15:0]        wave6_d, wave6_q;
  logic               sat6_d, sat6_q;
  assign scaled6 = p5_q[31:15];
  assign r6      = 18'(scaled6) + 18'(base_level_q);

  always_comb begin
    if (r6 > 18'sd32767) begin
      wave6_d = 16'h7fff;
      sat6_d  = 1'b1;
    end else if (r6 < -18'sd32768) begin
      wave6_d = 16'h8000;
      sat6_d  = 1'b1;
    end else begin
      wave6_d = r6[15:0];
      sat6_d  = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) d1_q <= d1_d;
    if (en2) x2_q <= x2_d;
    if (en3) begin
      n3_q <= n3_d;
      x3_q <= x2_q;
    end
    if (en4) begin
      alt4_q <= alt4_d;
      neg4_q <= quad4[1];
    end
    if (en5) p5_q <= p5_d;
    if (en6) begin
      wave6_q <= wave6_d;
      sat6_q  <= sat6_d;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = wave6_q;
  assign m_axis_tuser  = sat6_q;

endmodule

`default_nettype wire
